[sv/lab_pkg.sv]
package lab_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE_FX    = 1 << FRAC_BITS;
  localparam int NUDGE_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
  localparam int NUDGE_LSB = (NUDGE_RAW > 0) ? NUDGE_RAW : 1;

  // normaliser geometry: the largest magnitude is brought into [2^(NRM_MB-1), 2^NRM_MB)
  localparam int NRM_IW = 36;
  localparam int NRM_MB = 30;
  localparam int NRM_RW = NRM_MB + 1;
  localparam int NRM_SW = 2 * NRM_MB + 2;
  localparam int NRM_DW = NRM_MB + FRAC_BITS + 2;
  localparam int NRM_QW = FRAC_BITS + 1;
  localparam int NRM_PW = 6;

  localparam int MQ_DEPTH = 4;
  localparam int MQ_AW    = 2;

  typedef logic signed [17:0]     s18_t;
  typedef logic signed [32:0]     s33_t;
  typedef logic signed [35:0]     s36_t;
  typedef s18_t [2:0]             v18_t;
  typedef s33_t [2:0]             v33_t;
  typedef s36_t [2:0]             v36_t;
  typedef s36_t [5:0]             p6_t;

  typedef struct packed {
    v33_t d;
    v18_t sky;
  } mid_t;

  typedef struct packed {
    v18_t sky;
    v18_t fwd;
    v36_t rw;
    logic rwz;
  } bpay_t;

  typedef struct packed {
    v18_t side;
    v18_t top;
    v18_t front;
  } res_t;

  // the six partial products of a x b
  function automatic p6_t prod6(v18_t a, v18_t b);
    p6_t p;
    p[0] = s36_t'(a[1]) * s36_t'(b[2]);
    p[1] = s36_t'(a[2]) * s36_t'(b[1]);
    p[2] = s36_t'(a[2]) * s36_t'(b[0]);
    p[3] = s36_t'(a[0]) * s36_t'(b[2]);
    p[4] = s36_t'(a[0]) * s36_t'(b[1]);
    p[5] = s36_t'(a[1]) * s36_t'(b[0]);
    return p;
  endfunction

  function automatic v36_t cross_of(p6_t p);
    v36_t c;
    c[0] = p[0] - p[1];
    c[1] = p[2] - p[3];
    c[2] = p[4] - p[5];
    return c;
  endfunction

  // drop the fraction, rounding half away from zero, clamped to one
  function automatic s18_t rnd_frac(s36_t v);
    logic [35:0] m;
    logic [35:0] q;
    m = v[35] ? 36'(-v) : 36'(v);
    q = (m + 36'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (q > 36'(ONE_FX)) begin
      q = 36'(ONE_FX);
    end
    return v[35] ? -s18_t'(q) : s18_t'(q);
  endfunction

endpackage

[sv/look_at_basis_unit.sv]
// Camera basis unit: eye, target and world up in, right/up/forward out.
// Input side is a queue: an item goes in on a clock edge with push high and
// full low. Result side is a queue too: while empty is low the oldest basis
// sits on side_*, top_* and front_*; pop high on an edge takes it.
// A four-item queue after the front end (eye minus target) decouples it from
// the arithmetic pipeline, which runs three normalisers in series (forward,
// nudged forward, right), each with a one-bit-per-stage square root and a
// one-bit-per-stage divider.
// One item is taken and one basis delivered per cycle while pop keeps up.
// The pipeline ends in a two-item output buffer; when both are held the
// whole pipeline freezes, the queue fills and full rises, so nothing is lost.
// Reset (rst, synchronous) empties both queues and the pipeline, and the unit
// takes items straight after.
module look_at_basis_unit import lab_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] eye_x,
  input  logic [31:0] eye_y,
  input  logic [31:0] eye_z,
  input  logic [31:0] aim_x,
  input  logic [31:0] aim_y,
  input  logic [31:0] aim_z,
  input  logic [17:0] sky_x,
  input  logic [17:0] sky_y,
  input  logic [17:0] sky_z,
  output logic        empty,
  input  logic        pop,
  output logic [17:0] side_x,
  output logic [17:0] side_y,
  output logic [17:0] side_z,
  output logic [17:0] top_x,
  output logic [17:0] top_y,
  output logic [17:0] top_z,
  output logic [17:0] front_x,
  output logic [17:0] front_y,
  output logic [17:0] front_z
);

  logic mid_valid;
  mid_t mid_item;
  logic mid_pop;
  res_t res;

  lab_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
    .aim_x(aim_x), .aim_y(aim_y), .aim_z(aim_z),
    .sky_x(sky_x), .sky_y(sky_y), .sky_z(sky_z),
    .mid_valid(mid_valid), .mid_item(mid_item), .mid_pop(mid_pop)
  );

  lab_back u_back (
    .clk(clk), .rst(rst),
    .mid_valid(mid_valid), .mid_item(mid_item), .mid_pop(mid_pop),
    .empty(empty), .pop(pop), .res(res)
  );

  assign side_x  = res.side[0];
  assign side_y  = res.side[1];
  assign side_z  = res.side[2];
  assign top_x   = res.top[0];
  assign top_y   = res.top[1];
  assign top_z   = res.top[2];
  assign front_x = res.front[0];
  assign front_y = res.front[1];
  assign front_z = res.front[2];

endmodule

[sv/lab_front.sv]
module lab_front import lab_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] eye_x,
  input  logic [31:0] eye_y,
  input  logic [31:0] eye_z,
  input  logic [31:0] aim_x,
  input  logic [31:0] aim_y,
  input  logic [31:0] aim_z,
  input  logic [17:0] sky_x,
  input  logic [17:0] sky_y,
  input  logic [17:0] sky_z,
  output logic        mid_valid,
  output mid_t        mid_item,
  input  logic        mid_pop
);

  mid_t             mem [MQ_DEPTH];
  logic [MQ_AW-1:0] wp;
  logic [MQ_AW-1:0] rp;
  logic [MQ_AW:0]   cnt;
  mid_t             item;
  logic             wr;
  logic             rd;

  always_comb begin
    item.d[0]   = s33_t'($signed(eye_x)) - s33_t'($signed(aim_x));
    item.d[1]   = s33_t'($signed(eye_y)) - s33_t'($signed(aim_y));
    item.d[2]   = s33_t'($signed(eye_z)) - s33_t'($signed(aim_z));
    item.sky[0] = s18_t'(sky_x);
    item.sky[1] = s18_t'(sky_y);
    item.sky[2] = s18_t'(sky_z);
  end

  assign full      = (cnt == (MQ_AW+1)'(MQ_DEPTH));
  assign mid_valid = (cnt != '0);
  assign mid_item  = mem[rp];
  assign wr        = push && !full;
  assign rd        = mid_pop && mid_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= wp + 1'b1;
      end
      if (rd) begin
        rp <= rp + 1'b1;
      end
      if (wr && !rd) begin
        cnt <= cnt + 1'b1;
      end else if (rd && !wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

[sv/lab_nrm.sv]
module lab_nrm import lab_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  v36_t  in_vec,
  input  bpay_t in_pay,
  output logic  out_valid,
  output v18_t  out_vec,
  output bpay_t out_pay
);

  typedef struct packed {
    logic                        v;
    logic [2:0]                  neg;
    logic [2:0][NRM_IW-1:0]      m;
    bpay_t                       pay;
  } ma_t;

  typedef struct packed {
    logic                        v;
    logic [2:0]                  neg;
    logic                        zero;
    logic [NRM_PW-1:0]           pos;
    logic [2:0][NRM_IW-1:0]      m;
    bpay_t                       pay;
  } mb_t;

  typedef struct packed {
    logic                        v;
    logic [2:0]                  neg;
    logic                        zero;
    logic [2:0][NRM_MB-1:0]      m;
    bpay_t                       pay;
  } mc_t;

  typedef struct packed {
    logic                        v;
    logic [2:0]                  neg;
    logic                        zero;
    logic [2:0][NRM_MB-1:0]      m;
    logic [2:0][2*NRM_MB-1:0]    sq;
    bpay_t                       pay;
  } md_t;

  typedef struct packed {
    logic                        v;
    logic [2:0]                  neg;
    logic                        zero;
    logic [2:0][NRM_MB-1:0]      m;
    logic [NRM_SW-1:0]           rem;
    logic [NRM_RW-1:0]           root;
    bpay_t                       pay;
  } sq_t;

  typedef struct packed {
    logic                        v;
    logic [2:0]                  neg;
    logic                        zero;
    logic [NRM_RW-1:0]           r;
    logic [2:0][NRM_DW-1:0]      rem;
    logic [2:0][NRM_QW-1:0]      q;
    bpay_t                       pay;
  } dv_t;

  ma_t a, a_next;
  mb_t b, b_next;
  mc_t c, c_next;
  md_t d, d_next;
  sq_t sq [NRM_RW+1];
  sq_t e_next;
  dv_t dv [NRM_QW+1];
  dv_t dv0_next;
  logic  fin_v;
  v18_t  fin_vec;
  bpay_t fin_pay;

  // magnitudes and signs
  always_comb begin
    a_next.v   = in_valid;
    a_next.pay = in_pay;
    for (int i = 0; i < 3; i++) begin
      a_next.neg[i] = in_vec[i][NRM_IW-1];
      a_next.m[i]   = in_vec[i][NRM_IW-1] ? NRM_IW'(-in_vec[i]) : NRM_IW'(in_vec[i]);
    end
  end

  // leading one of the largest magnitude equals that of the OR of all three
  always_comb begin
    logic [NRM_IW-1:0] orv;
    orv         = a.m[0] | a.m[1] | a.m[2];
    b_next.v    = a.v;
    b_next.neg  = a.neg;
    b_next.m    = a.m;
    b_next.pay  = a.pay;
    b_next.zero = (orv == '0);
    b_next.pos  = '0;
    for (int j = 0; j < NRM_IW; j++) begin
      if (orv[j]) begin
        b_next.pos = NRM_PW'(j);
      end
    end
  end

  always_comb begin
    c_next.v    = b.v;
    c_next.neg  = b.neg;
    c_next.zero = b.zero;
    c_next.pay  = b.pay;
    for (int i = 0; i < 3; i++) begin
      if (b.pos >= NRM_PW'(NRM_MB - 1)) begin
        c_next.m[i] = NRM_MB'(b.m[i] >> (b.pos - NRM_PW'(NRM_MB - 1)));
      end else begin
        c_next.m[i] = NRM_MB'(b.m[i] << (NRM_PW'(NRM_MB - 1) - b.pos));
      end
    end
  end

  always_comb begin
    d_next.v    = c.v;
    d_next.neg  = c.neg;
    d_next.zero = c.zero;
    d_next.m    = c.m;
    d_next.pay  = c.pay;
    for (int i = 0; i < 3; i++) begin
      d_next.sq[i] = (2*NRM_MB)'(c.m[i]) * (2*NRM_MB)'(c.m[i]);
    end
  end

  always_comb begin
    e_next.v    = d.v;
    e_next.neg  = d.neg;
    e_next.zero = d.zero;
    e_next.m    = d.m;
    e_next.pay  = d.pay;
    e_next.rem  = NRM_SW'(d.sq[0]) + NRM_SW'(d.sq[1]) + NRM_SW'(d.sq[2]);
    e_next.root = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a     <= '0;
      b     <= '0;
      c     <= '0;
      d     <= '0;
      sq[0] <= '0;
    end else if (en) begin
      a     <= a_next;
      b     <= b_next;
      c     <= c_next;
      d     <= d_next;
      sq[0] <= e_next;
    end
  end

  // square root, one root bit per stage, remainder kept as S - root^2
  for (genvar k = 0; k < NRM_RW; k++) begin : g_sqrt
    localparam int BP = NRM_RW - 1 - k;
    sq_t              nx;
    logic [63:0]      t;
    always_comb begin
      nx = sq[k];
      t  = (64'(sq[k].root) << (BP + 1)) | (64'd1 << (2 * BP));
      if (64'(sq[k].rem) >= t) begin
        nx.rem  = sq[k].rem - NRM_SW'(t);
        nx.root = sq[k].root | (NRM_RW'(1) << BP);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq[k+1] <= '0;
      end else if (en) begin
        sq[k+1] <= nx;
      end
    end
  end

  // numerator m * 2^F + r/2 for the rounded quotient
  always_comb begin
    dv0_next.v    = sq[NRM_RW].v;
    dv0_next.neg  = sq[NRM_RW].neg;
    dv0_next.zero = sq[NRM_RW].zero;
    dv0_next.r    = sq[NRM_RW].root;
    dv0_next.pay  = sq[NRM_RW].pay;
    dv0_next.q    = '0;
    for (int i = 0; i < 3; i++) begin
      dv0_next.rem[i] = (NRM_DW'(sq[NRM_RW].m[i]) << FRAC_BITS)
                      + NRM_DW'(sq[NRM_RW].root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= '0;
    end else if (en) begin
      dv[0] <= dv0_next;
    end
  end

  // restoring division, one quotient bit per stage on all three lanes
  for (genvar j = 0; j < NRM_QW; j++) begin : g_div
    localparam int KB = NRM_QW - 1 - j;
    dv_t              nx;
    logic [NRM_DW-1:0] dd;
    always_comb begin
      nx = dv[j];
      dd = NRM_DW'(dv[j].r) << KB;
      for (int i = 0; i < 3; i++) begin
        if (dv[j].rem[i] >= dd) begin
          nx.rem[i] = dv[j].rem[i] - dd;
          nx.q[i]   = dv[j].q[i] | (NRM_QW'(1) << KB);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= '0;
      end else if (en) begin
        dv[j+1] <= nx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_v <= 1'b0;
    end else if (en) begin
      fin_v <= dv[NRM_QW].v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_pay <= dv[NRM_QW].pay;
      for (int i = 0; i < 3; i++) begin
        if (dv[NRM_QW].zero) begin
          fin_vec[i] <= '0;
        end else if (dv[NRM_QW].q[i] > NRM_QW'(ONE_FX)) begin
          fin_vec[i] <= dv[NRM_QW].neg[i] ? -s18_t'(ONE_FX) : s18_t'(ONE_FX);
        end else begin
          fin_vec[i] <= dv[NRM_QW].neg[i] ? -s18_t'(dv[NRM_QW].q[i])
                                          : s18_t'(dv[NRM_QW].q[i]);
        end
      end
    end
  end

  assign out_valid = fin_v;
  assign out_vec   = fin_vec;
  assign out_pay   = fin_pay;

endmodule

[sv/lab_back.sv]
module lab_back import lab_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic mid_valid,
  input  mid_t mid_item,
  output logic mid_pop,
  output logic empty,
  input  logic pop,
  output res_t res
);

  typedef struct packed {
    logic  v;
    bpay_t pay;
    v18_t  vec;
    p6_t   p;
  } ps_t;

  logic        en;
  logic [1:0]  ocnt;
  logic        owp;
  logic        orp;
  res_t        ob [2];

  v36_t  n1_in;
  bpay_t n1_pin;
  logic  n1_v, n2_v, n3_v;
  v18_t  n1_vec, n2_vec, n3_vec;
  bpay_t n1_pay, n2_pay, n3_pay;

  ps_t   s1, s1_next, s3, s3_next, s5, s5_next;
  logic  s2_v, s4_v, s6_v;
  v36_t  s2_vec, s2_vec_next, s4_vec, s4_vec_next;
  bpay_t s2_pay, s2_pay_next, s4_pay, s4_pay_next;
  res_t  s6, s6_next;

  // whole back pipeline holds while both output slots are taken
  assign en      = (ocnt != 2'd2);
  assign mid_pop = en;

  always_comb begin
    n1_pin     = '0;
    n1_pin.sky = mid_item.sky;
    for (int i = 0; i < 3; i++) begin
      n1_in[i] = s36_t'(mid_item.d[i]);
    end
  end

  lab_nrm u_nrm_fwd (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(mid_valid), .in_vec(n1_in), .in_pay(n1_pin),
    .out_valid(n1_v), .out_vec(n1_vec), .out_pay(n1_pay)
  );

  // coincident eye and aim look down +z
  always_comb begin
    v18_t f;
    f = n1_vec;
    if (n1_vec[0] == '0 && n1_vec[1] == '0 && n1_vec[2] == '0) begin
      f[2] = s18_t'(ONE_FX);
    end
    s1_next.v       = n1_v;
    s1_next.pay     = n1_pay;
    s1_next.pay.fwd = f;
    s1_next.vec     = f;
    s1_next.p       = prod6(n1_pay.sky, f);
  end

  // nudged forward always goes round again; used when sky is parallel to forward
  always_comb begin
    v36_t c;
    logic zx;
    c  = cross_of(s1.p);
    zx = ($signed(s1.pay.sky[2]) == ONE_FX) || ($signed(s1.pay.sky[2]) == -ONE_FX);
    s2_pay_next     = s1.pay;
    s2_pay_next.rw  = c;
    s2_pay_next.rwz = (c[0] == '0) && (c[1] == '0) && (c[2] == '0);
    for (int i = 0; i < 3; i++) begin
      s2_vec_next[i] = s36_t'(s1.vec[i]);
    end
    if (zx) begin
      s2_vec_next[0] = s2_vec_next[0] + s36_t'(NUDGE_LSB);
    end else begin
      s2_vec_next[2] = s2_vec_next[2] + s36_t'(NUDGE_LSB);
    end
  end

  lab_nrm u_nrm_nudge (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s2_v), .in_vec(s2_vec), .in_pay(s2_pay),
    .out_valid(n2_v), .out_vec(n2_vec), .out_pay(n2_pay)
  );

  always_comb begin
    s3_next.v   = n2_v;
    s3_next.pay = n2_pay;
    s3_next.vec = n2_vec;
    s3_next.p   = prod6(n2_pay.sky, n2_vec);
  end

  always_comb begin
    v36_t c;
    c           = cross_of(s3.p);
    s4_pay_next = s3.pay;
    s4_vec_next = s3.pay.rw;
    if (s3.pay.rwz) begin
      s4_pay_next.fwd = s3.vec;
      s4_vec_next     = c;
    end
  end

  lab_nrm u_nrm_side (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s4_v), .in_vec(s4_vec), .in_pay(s4_pay),
    .out_valid(n3_v), .out_vec(n3_vec), .out_pay(n3_pay)
  );

  always_comb begin
    s5_next.v   = n3_v;
    s5_next.pay = n3_pay;
    s5_next.vec = n3_vec;
    s5_next.p   = prod6(n3_pay.fwd, n3_vec);
  end

  always_comb begin
    v36_t c;
    c             = cross_of(s5.p);
    s6_next.side  = s5.vec;
    s6_next.front = s5.pay.fwd;
    for (int i = 0; i < 3; i++) begin
      s6_next.top[i] = rnd_frac(c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1   <= '0;
      s3   <= '0;
      s5   <= '0;
      s2_v <= 1'b0;
      s4_v <= 1'b0;
      s6_v <= 1'b0;
    end else if (en) begin
      s1   <= s1_next;
      s3   <= s3_next;
      s5   <= s5_next;
      s2_v <= s1.v;
      s4_v <= s3.v;
      s6_v <= s5.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_vec <= s2_vec_next;
      s2_pay <= s2_pay_next;
      s4_vec <= s4_vec_next;
      s4_pay <= s4_pay_next;
      s6     <= s6_next;
    end
  end

  // two-item output buffer
  always_ff @(posedge clk) begin
    if (en && s6_v) begin
      ob[owp] <= s6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= '0;
      owp  <= 1'b0;
      orp  <= 1'b0;
    end else begin
      if (en && s6_v) begin
        owp <= ~owp;
      end
      if (pop && !empty) begin
        orp <= ~orp;
      end
      if ((en && s6_v) && !(pop && !empty)) begin
        ocnt <= ocnt + 2'd1;
      end else if (!(en && s6_v) && (pop && !empty)) begin
        ocnt <= ocnt - 2'd1;
      end
    end
  end

  assign empty = (ocnt == '0);
  assign res   = ob[orp];

endmodule
